// ===== rtl/sm4_gcm_encrypt_core_defines.svh =====
// assertion macros used by the core rtl file
`ifndef SM4_GCM_ENCRYPT_CORE_DEFINES_SVH
`define SM4_GCM_ENCRYPT_CORE_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define SM4G_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sm4g assertion failed");

// next-cycle implication
`define SM4G_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sm4g assertion failed");

`endif

// ===== rtl/sm4g_pkg.sv =====
`default_nettype none
package sm4g_pkg;

  typedef enum logic [2:0] {
    ST_IDLE, ST_KEXP, ST_EPRE, ST_ENC, ST_GHASH, ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    REQ_START  = 2'd0,
    REQ_AAD    = 2'd1,
    REQ_TEXT   = 2'd2,
    REQ_FINISH = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    CFG_KEY_HIGH   = 2'd0,
    CFG_KEY_LOW    = 2'd1,
    CFG_NONCE_HIGH = 2'd2,
    CFG_NONCE_LOW  = 2'd3
  } cfg_e;

  typedef struct packed {
    logic         start;
    logic [127:0] x;
  } ghash_req_t;

  typedef struct packed {
    logic         done;
    logic [127:0] z;
  } ghash_rsp_t;

  localparam logic [127:0] FK = 128'ha3b1bac6_56aa3350_677d9197_b27022dc;
  localparam logic [7:0]   GF_POLY = 8'he1;
  localparam int           ROUNDS = 32;
  localparam int           RND_W = $clog2(ROUNDS);
  localparam int           GH_STEPS = 4;
  localparam int           GH_CNT_W = $clog2(128 / GH_STEPS);

  localparam logic [7:0] SBOX [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  function automatic logic [31:0] tau(input logic [31:0] x);
    return {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
  endfunction

  function automatic logic [31:0] rotl(input logic [31:0] x, input int s);
    return (x << s) | (x >> (32 - s));
  endfunction

  // linear layer of the data rounds
  function automatic logic [31:0] l_enc(input logic [31:0] b);
    return b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
  endfunction

  // linear layer of the key schedule
  function automatic logic [31:0] l_key(input logic [31:0] b);
    return b ^ rotl(b, 13) ^ rotl(b, 23);
  endfunction

  // byte j of word i is (4i+j)*7 mod 256
  function automatic logic [31:0] ck_word(input logic [RND_W-1:0] i);
    logic [31:0] w;
    logic [7:0]  idx;
    w = '0;
    for (int j = 0; j < 4; j++) begin
      idx = {1'b0, i, 2'(j)};
      w[31 - 8*j -: 8] = 8'(idx * 8'd7);
    end
    return w;
  endfunction

  function automatic logic [4:0] norm_bytes(input logic [4:0] nb);
    return (nb == 5'd0 || nb > 5'd16) ? 5'd16 : nb;
  endfunction

  function automatic logic [127:0] byte_mask(input logic [4:0] nb);
    logic [127:0] m;
    m = '0;
    for (int k = 0; k < 16; k++) begin
      m[127 - 8*k -: 8] = (5'(k) < nb) ? 8'hff : 8'h00;
    end
    return m;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/sm4g_if.sv =====
`default_nettype none
interface sm4g_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [63:0] chunk_high;
  logic [63:0] chunk_low;
  logic [4:0]  chunk_bytes;
  modport source(output valid, req_type, chunk_high, chunk_low, chunk_bytes, input ready);
  modport sink(input valid, req_type, chunk_high, chunk_low, chunk_bytes, output ready);
endinterface

interface sm4g_res_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_high;
  logic [63:0] result_low;
  logic [4:0]  result_bytes;
  logic        is_tag;
  logic        order_error;
  modport source(output valid, result_high, result_low, result_bytes, is_tag, order_error,
                 input ready);
  modport sink(input valid, result_high, result_low, result_bytes, is_tag, order_error,
               output ready);
endinterface

interface sm4g_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/sm4g_ram.sv =====
`default_nettype none
module sm4g_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

// ===== rtl/sm4g_ghash.sv =====
`default_nettype none
module sm4g_ghash (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire sm4g_pkg::ghash_req_t   req_i,
  input  wire logic [127:0]           h_i,
  output sm4g_pkg::ghash_rsp_t        rsp_o
);
  import sm4g_pkg::*;

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [GH_CNT_W-1:0] cnt_q, cnt_d;
  logic [127:0]        z_q, z_d, v_q, v_d, x_q, x_d;

  // four multiply steps per cycle, msb of x first
  always_comb begin
    logic [127:0] z, v, x;
    logic         lsb;
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    lsb = 1'b0;
    z = z_q;
    v = v_q;
    x = x_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      z = '0;
      v = h_i;
      x = req_i.x;
    end else if (busy_q) begin
      for (int s = 0; s < GH_STEPS; s++) begin
        if (x[127]) begin
          z = z ^ v;
        end
        lsb = v[0];
        v = v >> 1;
        if (lsb) begin
          v[127:120] = v[127:120] ^ GF_POLY;
        end
        x = x << 1;
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == '1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
    z_d = z;
    v_d = v;
    x_d = x;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    z_q <= z_d;
    v_q <= v_d;
    x_q <= x_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.z    = z_q;
endmodule
`default_nettype wire

// ===== rtl/sm4_gcm_encrypt_core.sv =====
// SM4-GCM encryption core, 96-bit IV, one chunk of up to 16 bytes per transfer.
// cfg_i writes key and nonce registers (index 0..3); always ready. The user
// writes them only while idle; the core itself does not enforce this.
// req_i takes one item at a time; ready is high only when the core is idle.
//   start:  key expansion (round keys into a 32x32 RAM), then
//           E(0) and E(IV||1); no result
//   aad:    one GHASH multiply, 4 bits a cycle, no result
//   text:   SM4 (one round a cycle, round key read from the RAM in the cycle
//           before its round), result in the output register, then GHASH of it
//   finish: GHASH of the length block, then the tag
// res_o is a registered output; a stalled receiver holds the result and the
// core waits with it before the text chunk's hash step.
// Reset clears the control state, counter (to 2), GHASH, lengths and flags;
// the round key RAM holds nothing until the first start.
`default_nettype none
`include "sm4_gcm_encrypt_core_defines.svh"
module sm4_gcm_encrypt_core (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  sm4g_cfg_if.sink   cfg_i,
  sm4g_req_if.sink   req_i,
  sm4g_res_if.source res_o
);
  import sm4g_pkg::*;

  state_e           state_q, state_d;
  logic [RND_W-1:0] rnd_q, rnd_d;
  req_e             op_q, op_d;
  logic             sel_q, sel_d;

  logic [63:0]  key_hi_q, key_lo_q, nonce_hi_q;
  logic [31:0]  nonce_lo_q;
  logic [127:0] kw_q, kw_d, s_q, s_d;
  logic [127:0] h_q, h_d, tm_q, tm_d, acc_q, acc_d;
  logic [31:0]  ctr_q, ctr_d;
  logic [63:0]  aad_len_q, aad_len_d, txt_len_q, txt_len_d;
  logic         seen_q, seen_d, err_q, err_d;
  logic [127:0] chunk_q, chunk_d, mask_q, mask_d, ct_q, ct_d;
  logic [4:0]   nb_q, nb_d;

  logic         out_valid_q, out_valid_d;
  logic [127:0] out_data_q, out_data_d;
  logic [4:0]   out_bytes_q, out_bytes_d;
  logic         out_tag_q, out_tag_d, out_err_q, out_err_d;

  logic             rk_we;
  logic [RND_W-1:0] rk_waddr, rk_raddr;
  logic [31:0]      rk_wdata, rk_rdata;
  ghash_req_t       gh_req;
  ghash_rsp_t       gh_rsp;

  logic         req_xfer, out_free, last_rnd;
  logic [4:0]   in_nb;
  logic [127:0] in_mask, in_chunk, res_blk;
  logic [31:0]  k_t, k_n, e_n;

  sm4g_ram #(.WIDTH(32), .DEPTH(ROUNDS)) u_rk_ram (
    .clk_i   (clk_i),
    .we_i    (rk_we),
    .waddr_i (rk_waddr),
    .wdata_i (rk_wdata),
    .raddr_i (rk_raddr),
    .rdata_o (rk_rdata)
  );

  sm4g_ghash u_ghash (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (gh_req),
    .h_i    (h_q),
    .rsp_o  (gh_rsp)
  );

  assign cfg_i.ready = 1'b1;
  assign req_i.ready = (state_q == ST_IDLE);
  assign req_xfer    = req_i.valid && req_i.ready;
  assign out_free    = !out_valid_q || res_o.ready;
  assign last_rnd    = (rnd_q == RND_W'(ROUNDS - 1));

  assign in_nb    = norm_bytes(req_i.chunk_bytes);
  assign in_mask  = byte_mask(in_nb);
  assign in_chunk = {req_i.chunk_high, req_i.chunk_low} & in_mask;

  // key schedule round and data round
  assign k_t = l_key(tau(kw_q[95:64] ^ kw_q[63:32] ^ kw_q[31:0] ^ ck_word(rnd_q)));
  assign k_n = kw_q[127:96] ^ k_t;
  assign e_n = s_q[127:96] ^ l_enc(tau(s_q[95:64] ^ s_q[63:32] ^ s_q[31:0] ^ rk_rdata));
  // output word order is reversed after the last round
  assign res_blk = {e_n, s_q[31:0], s_q[63:32], s_q[95:64]};

  assign rk_we    = (state_q == ST_KEXP);
  assign rk_waddr = rnd_q;
  assign rk_wdata = k_n;
  // prefetch: the key for the next round is read in the cycle before its round
  assign rk_raddr = (state_q == ST_ENC) ? rnd_q + 1'b1 : '0;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_xfer) begin
          unique case (req_e'(req_i.req_type))
            REQ_START:           state_d = ST_KEXP;
            REQ_TEXT:            state_d = ST_EPRE;
            REQ_AAD, REQ_FINISH: state_d = ST_GHASH;
            default:             state_d = ST_IDLE;
          endcase
        end
      end
      ST_KEXP:  if (last_rnd) state_d = ST_EPRE;
      ST_EPRE:  state_d = ST_ENC;
      ST_ENC: begin
        if (last_rnd) begin
          if (op_q == REQ_TEXT) begin
            state_d = ST_OUT;
          end else if (!sel_q) begin
            state_d = ST_EPRE;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_GHASH: begin
        if (gh_rsp.done) state_d = (op_q == REQ_FINISH) ? ST_OUT : ST_IDLE;
      end
      ST_OUT: begin
        if (out_free) state_d = (op_q == REQ_TEXT) ? ST_GHASH : ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    rnd_d = rnd_q;  op_d = op_q;  sel_d = sel_q;
    kw_d = kw_q;  s_d = s_q;  h_d = h_q;  tm_d = tm_q;  acc_d = acc_q;
    ctr_d = ctr_q;  aad_len_d = aad_len_q;  txt_len_d = txt_len_q;
    seen_d = seen_q;  err_d = err_q;
    chunk_d = chunk_q;  mask_d = mask_q;  ct_d = ct_q;  nb_d = nb_q;
    out_valid_d = out_valid_q && !res_o.ready;
    out_data_d = out_data_q;  out_bytes_d = out_bytes_q;
    out_tag_d = out_tag_q;  out_err_d = out_err_q;
    gh_req.start = 1'b0;
    gh_req.x     = acc_q ^ chunk_q;

    unique case (state_q)
      ST_IDLE: begin
        if (req_xfer) begin
          op_d    = req_e'(req_i.req_type);
          chunk_d = in_chunk;
          mask_d  = in_mask;
          nb_d    = in_nb;
          rnd_d   = '0;
          unique case (req_e'(req_i.req_type))
            REQ_START: begin
              kw_d = {key_hi_q, key_lo_q} ^ FK;
              sel_d = 1'b0;
              ctr_d = 32'd2;
              acc_d = '0;
              aad_len_d = '0;
              txt_len_d = '0;
              seen_d = 1'b0;
              err_d = 1'b0;
            end
            REQ_AAD: begin
              err_d = err_q | seen_q;
              aad_len_d = aad_len_q + (64'(in_nb) << 3);
              gh_req.start = 1'b1;
              gh_req.x = acc_q ^ in_chunk;
            end
            REQ_TEXT: begin
              s_d = {nonce_hi_q, nonce_lo_q, ctr_q};
              ctr_d = ctr_q + 1'b1;
              txt_len_d = txt_len_q + (64'(in_nb) << 3);
              seen_d = 1'b1;
            end
            REQ_FINISH: begin
              gh_req.start = 1'b1;
              gh_req.x = acc_q ^ {aad_len_q, txt_len_q};
            end
            default: ;
          endcase
        end
      end
      ST_KEXP: begin
        kw_d = {kw_q[95:0], k_n};
        rnd_d = rnd_q + 1'b1;
        if (last_rnd) s_d = '0;
      end
      ST_EPRE: rnd_d = '0;
      ST_ENC: begin
        s_d = {s_q[95:0], e_n};
        rnd_d = rnd_q + 1'b1;
        if (last_rnd) begin
          if (op_q == REQ_TEXT) begin
            ct_d = (chunk_q ^ res_blk) & mask_q;
          end else if (!sel_q) begin
            h_d = res_blk;
            s_d = {nonce_hi_q, nonce_lo_q, 32'd1};
            sel_d = 1'b1;
          end else begin
            tm_d = res_blk;
          end
        end
      end
      ST_GHASH: if (gh_rsp.done) acc_d = gh_rsp.z;
      ST_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_err_d = err_q;
          if (op_q == REQ_TEXT) begin
            out_data_d = ct_q;
            out_bytes_d = nb_q;
            out_tag_d = 1'b0;
            gh_req.start = 1'b1;
            gh_req.x = acc_q ^ ct_q;
          end else begin
            out_data_d = acc_q ^ tm_q;
            out_bytes_d = 5'd16;
            out_tag_d = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rnd_q       <= '0;
      op_q        <= REQ_START;
      sel_q       <= 1'b0;
      out_valid_q <= 1'b0;
      key_hi_q    <= '0;
      key_lo_q    <= '0;
      nonce_hi_q  <= '0;
      nonce_lo_q  <= '0;
      h_q         <= '0;
      tm_q        <= '0;
      acc_q       <= '0;
      ctr_q       <= 32'd2;
      aad_len_q   <= '0;
      txt_len_q   <= '0;
      seen_q      <= 1'b0;
      err_q       <= 1'b0;
    end else begin
      state_q     <= state_d;
      rnd_q       <= rnd_d;
      op_q        <= op_d;
      sel_q       <= sel_d;
      out_valid_q <= out_valid_d;
      h_q         <= h_d;
      tm_q        <= tm_d;
      acc_q       <= acc_d;
      ctr_q       <= ctr_d;
      aad_len_q   <= aad_len_d;
      txt_len_q   <= txt_len_d;
      seen_q      <= seen_d;
      err_q       <= err_d;
      if (cfg_i.valid && cfg_i.ready) begin
        unique case (cfg_e'(cfg_i.index))
          CFG_KEY_HIGH:   key_hi_q   <= cfg_i.data;
          CFG_KEY_LOW:    key_lo_q   <= cfg_i.data;
          CFG_NONCE_HIGH: nonce_hi_q <= cfg_i.data;
          CFG_NONCE_LOW:  nonce_lo_q <= cfg_i.data[31:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kw_q        <= kw_d;
    s_q         <= s_d;
    chunk_q     <= chunk_d;
    mask_q      <= mask_d;
    ct_q        <= ct_d;
    nb_q        <= nb_d;
    out_data_q  <= out_data_d;
    out_bytes_q <= out_bytes_d;
    out_tag_q   <= out_tag_d;
    out_err_q   <= out_err_d;
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.result_high  = out_data_q[127:64];
  assign res_o.result_low   = out_data_q[63:0];
  assign res_o.result_bytes = out_bytes_q;
  assign res_o.is_tag       = out_tag_q;
  assign res_o.order_error  = out_err_q;

  `SM4G_ASSERT_NEXT(a_text_goes_to_enc, req_xfer && req_i.req_type == REQ_TEXT, state_q == ST_EPRE)
  `SM4G_ASSERT_NOW(a_ghash_done_in_state, gh_rsp.done, state_q == ST_GHASH)
  `SM4G_ASSERT_NOW(a_result_from_out, $rose(res_o.valid), $past(state_q) == ST_OUT)
endmodule
`default_nettype wire

// ===== dv/tb_sm4g_if.sv =====
`timescale 1ns / 100ps
`default_nettype none
// testbench copy of the channel bundles lives in the rtl; this file only hosts
// a small holder for the expected result record used by tb_top
package tb_sm4g_pkg;
  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
    logic [4:0]  nbytes;
    logic        tag;
    logic        err;
  } gcm_result_t;
endpackage
`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import sm4g_pkg::*;
  import tb_sm4g_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  sm4g_cfg_if cfg_if();
  sm4g_req_if req_if();
  sm4g_res_if res_if();

  sm4_gcm_encrypt_core dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if.sink),
    .req_i (req_if.sink),
    .res_o (res_if.source)
  );

  // ---------------- predictor of the cipher and hash ----------------
  logic [63:0]  key_hi, key_lo, iv_hi;
  logic [31:0]  iv_lo;
  logic [31:0]  rk [32];
  logic [127:0] h_key, t_mask, acc;
  logic [31:0]  ctr;
  logic [63:0]  aad_bits, txt_bits;
  logic         seen_text, ord_err;

  function automatic logic [31:0] sub_word(logic [31:0] x);
    return {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
  endfunction

  function automatic logic [31:0] rol(logic [31:0] x, int s);
    return (x << s) | (x >> (32 - s));
  endfunction

  function automatic void make_round_keys();
    logic [31:0] w [4];
    logic [31:0] t, n, ck;
    w[0] = key_hi[63:32] ^ FK[127:96];
    w[1] = key_hi[31:0] ^ FK[95:64];
    w[2] = key_lo[63:32] ^ FK[63:32];
    w[3] = key_lo[31:0] ^ FK[31:0];
    for (int i = 0; i < 32; i++) begin
      for (int j = 0; j < 4; j++) ck[31 - 8*j -: 8] = 8'((4*i + j) * 7);
      t = sub_word(w[1] ^ w[2] ^ w[3] ^ ck);
      n = w[0] ^ t ^ rol(t, 13) ^ rol(t, 23);
      w[0] = w[1]; w[1] = w[2]; w[2] = w[3]; w[3] = n;
      rk[i] = n;
    end
  endfunction

  function automatic logic [127:0] cipher(logic [127:0] blk);
    logic [31:0] s0, s1, s2, s3, t, n;
    {s0, s1, s2, s3} = blk;
    for (int i = 0; i < 32; i++) begin
      t = sub_word(s1 ^ s2 ^ s3 ^ rk[i]);
      n = s0 ^ t ^ rol(t, 2) ^ rol(t, 10) ^ rol(t, 18) ^ rol(t, 24);
      s0 = s1; s1 = s2; s2 = s3; s3 = n;
    end
    return {s3, s2, s1, s0};
  endfunction

  function automatic void absorb(logic [127:0] blk);
    logic [127:0] x, z, v;
    logic         lsb;
    x = acc ^ blk;
    z = '0;
    v = h_key;
    for (int i = 0; i < 128; i++) begin
      if (x[127 - i]) z ^= v;
      lsb = v[0];
      v = v >> 1;
      if (lsb) v[127:120] ^= 8'he1;
    end
    acc = z;
  endfunction

  task automatic predict_reset();
    key_hi = '0; key_lo = '0; iv_hi = '0; iv_lo = '0;
    h_key = '0; t_mask = '0; acc = '0; ctr = 32'd2;
    aad_bits = '0; txt_bits = '0; seen_text = 1'b0; ord_err = 1'b0;
  endtask

  // returns 1 when the item yields a result
  function automatic bit encrypt_step(req_e kind, logic [63:0] c_hi, logic [63:0] c_lo,
                                      logic [4:0] c_nb, output gcm_result_t r);
    logic [127:0] m, d, ks;
    logic [4:0]   nb;
    nb = (c_nb == 0 || c_nb > 16) ? 5'd16 : c_nb;
    m = '0;
    for (int k = 0; k < 16; k++) if (k < nb) m[127 - 8*k -: 8] = 8'hff;
    d = {c_hi, c_lo} & m;
    r = '0;
    case (kind)
      REQ_START: begin
        make_round_keys();
        h_key = cipher('0);
        t_mask = cipher({iv_hi, iv_lo, 32'd1});
        ctr = 32'd2; acc = '0; aad_bits = '0; txt_bits = '0;
        seen_text = 1'b0; ord_err = 1'b0;
        return 0;
      end
      REQ_AAD: begin
        if (seen_text) ord_err = 1'b1;
        absorb(d);
        aad_bits += 64'(8 * nb);
        return 0;
      end
      REQ_TEXT: begin
        ks = cipher({iv_hi, iv_lo, ctr});
        ctr++;
        d = (d ^ ks) & m;
        absorb(d);
        txt_bits += 64'(8 * nb);
        seen_text = 1'b1;
        r = '{d[127:64], d[63:0], nb, 1'b0, ord_err};
        return 1;
      end
      default: begin
        absorb({aad_bits, txt_bits});
        r = '{acc[127:64] ^ t_mask[127:64], acc[63:0] ^ t_mask[63:0], 5'd16, 1'b1, ord_err};
        return 1;
      end
    endcase
  endfunction

  // ---------------- scoreboard ----------------
  class gcm_scoreboard;
    gcm_result_t pending[$];
    int errors = 0;

    function void note_item(req_e kind, logic [63:0] hi, logic [63:0] lo, logic [4:0] nb);
      gcm_result_t r;
      if (encrypt_step(kind, hi, lo, nb, r)) pending.push_back(r);
    endfunction

    function void check_result(gcm_result_t got);
      gcm_result_t e;
      if (pending.size() == 0) begin
        $error("unexpected result hi=%h lo=%h", got.hi, got.lo);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.hi !== e.hi) begin
        $error("result_high exp=%h act=%h", e.hi, got.hi); errors++;
      end
      if (got.lo !== e.lo) begin
        $error("result_low exp=%h act=%h", e.lo, got.lo); errors++;
      end
      if (got.nbytes !== e.nbytes) begin
        $error("result_bytes exp=%0d act=%0d", e.nbytes, got.nbytes); errors++;
      end
      if (got.tag !== e.tag) begin
        $error("is_tag exp=%b act=%b", e.tag, got.tag); errors++;
      end
      if (got.err !== e.err) begin
        $error("order_error exp=%b act=%b", e.err, got.err); errors++;
      end
    endfunction
  endclass

  gcm_scoreboard sb = new();
  bit quiet = 1'b0;   // no idling in the final stretch
  int cycles = 0;

  // ---------------- driving ----------------
  initial begin
    cfg_if.valid = 1'b0; cfg_if.index = CFG_KEY_HIGH; cfg_if.data = '0;
    req_if.valid = 1'b0; req_if.req_type = REQ_START;
    req_if.chunk_high = '0; req_if.chunk_low = '0; req_if.chunk_bytes = 5'd16;
    res_if.ready = 1'b0;
  end

  task automatic write_reg(cfg_e idx, logic [63:0] val);
    @(negedge clk_i);
    cfg_if.valid = 1'b1; cfg_if.index = idx; cfg_if.data = val;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      CFG_KEY_HIGH:   key_hi = val;
      CFG_KEY_LOW:    key_lo = val;
      CFG_NONCE_HIGH: iv_hi = val;
      default:        iv_lo = val[31:0];
    endcase
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  task automatic send(req_e kind, logic [63:0] hi, logic [63:0] lo, logic [4:0] nb);
    @(negedge clk_i);
    if (!quiet && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 16)) @(negedge clk_i);
    req_if.valid = 1'b1; req_if.req_type = kind;
    req_if.chunk_high = hi; req_if.chunk_low = lo; req_if.chunk_bytes = nb;
    do @(posedge clk_i); while (!req_if.ready);
    sb.note_item(kind, hi, lo, nb);
    @(negedge clk_i);
    req_if.valid = 1'b0;
  endtask

  // settle: all results in, then the latency of a non-result item
  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (120) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [4:0] rnd_nb();
    case ($urandom_range(0, 9))
      0: return 5'($urandom_range(0, 31));
      1, 2: return 5'($urandom_range(1, 15));
      default: return 5'd16;
    endcase
  endfunction

  task automatic random_message();
    int n_aad, n_txt;
    n_aad = $urandom_range(0, 3);
    n_txt = $urandom_range(0, 6);
    send(REQ_START, rnd64(), rnd64(), rnd_nb());
    repeat (n_aad) send(REQ_AAD, rnd64(), rnd64(), rnd_nb());
    repeat (n_txt) send(REQ_TEXT, rnd64(), rnd64(), rnd_nb());
    if ($urandom_range(0, 5) == 0) send(REQ_AAD, rnd64(), rnd64(), rnd_nb());
    if ($urandom_range(0, 7) == 0) send(REQ_TEXT, rnd64(), rnd64(), rnd_nb());
    send(REQ_FINISH, rnd64(), rnd64(), rnd_nb());
    if ($urandom_range(0, 7) == 0) send(REQ_FINISH, rnd64(), rnd64(), rnd_nb());
  endtask

  // receiver with bursty stalls
  always @(negedge clk_i) begin
    if (!rst_ni) res_if.ready <= 1'b0;
    else if (!quiet && $urandom_range(0, 7) == 0) begin
      res_if.ready <= 1'b0;
      repeat ($urandom_range(1, 16) - 1) @(negedge clk_i);
    end else res_if.ready <= 1'b1;
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready)
      sb.check_result('{res_if.result_high, res_if.result_low, res_if.result_bytes,
                        res_if.is_tag, res_if.order_error});
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 1500000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int sent;
    predict_reset();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: extremes, every request kind, ordering error, odd byte counts
    write_reg(CFG_KEY_HIGH, '1);
    write_reg(CFG_KEY_LOW, '1);
    write_reg(CFG_NONCE_HIGH, '1);
    write_reg(CFG_NONCE_LOW, 64'hffff_ffff_ffff_ffff);
    send(REQ_START, '0, '0, 5'd16);
    send(REQ_AAD, '1, '1, 5'd16);
    send(REQ_AAD, '1, '1, 5'd1);
    send(REQ_TEXT, '1, '1, 5'd16);
    send(REQ_TEXT, '0, '0, 5'd8);
    send(REQ_TEXT, '1, '1, 5'd0);
    send(REQ_TEXT, '1, '1, 5'd31);
    send(REQ_TEXT, '1, '1, 5'd15);
    send(REQ_AAD, '1, '1, 5'd9);
    send(REQ_TEXT, 64'h0123456789abcdef, 64'hfedcba9876543210, 5'd17);
    send(REQ_FINISH, '0, '0, 5'd16);
    send(REQ_FINISH, '1, '1, 5'd3);
    drain();
    write_reg(CFG_KEY_HIGH, '0);
    write_reg(CFG_KEY_LOW, '0);
    write_reg(CFG_NONCE_HIGH, '0);
    write_reg(CFG_NONCE_LOW, '0);
    send(REQ_START, '0, '0, 5'd16);
    send(REQ_FINISH, '0, '0, 5'd16);
    send(REQ_START, '1, '1, 5'd16);
    send(REQ_TEXT, '0, '0, 5'd16);
    send(REQ_FINISH, '0, '0, 5'd16);

    sent = 0;
    while (sent < 1600) begin
      if ($urandom_range(0, 9) == 0) begin
        drain();
        write_reg(cfg_e'($urandom_range(0, 3)), rnd64());
        if ($urandom_range(0, 1) == 0) write_reg(CFG_KEY_LOW, rnd64());
      end
      if (sent > 1450) quiet = 1'b1;
      random_message();
      // a message carries about seven items on average
      sent += 7;
    end

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (sb.errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+rtl
rtl/sm4g_pkg.sv
rtl/sm4g_if.sv
rtl/sm4g_ram.sv
rtl/sm4g_ghash.sv
rtl/sm4_gcm_encrypt_core.sv
dv/tb_sm4g_if.sv
dv/tb_top.sv
